>>> rtl/audio_packet_loss_fill_buffer_assert.svh
// assertion macros for the packet loss fill buffer
`ifndef AUDIO_PACKET_LOSS_FILL_BUFFER_ASSERT_SVH
`define AUDIO_PACKET_LOSS_FILL_BUFFER_ASSERT_SVH

// property that holds on every clock edge outside reset
`define APL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on the next clock edge
`define APL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/apl_pkg.sv
// ----------------------------------------------------------------------------
// apl_pkg
// shared types and constants of the packet loss fill buffer
// ----------------------------------------------------------------------------
package apl_pkg;

  localparam int unsigned RingDepthDefault = 32768;

  localparam logic [15:0] SyncReset      = 16'hA55A;
  localparam logic [7:0]  MaxPayReset    = 8'd200;
  localparam logic [7:0]  SilenceReset   = 8'd128;
  localparam logic [15:0] ThreshReset    = 16'd1024;
  localparam logic [12:0] BlockReset     = 13'd256;
  localparam int unsigned HeaderLen      = 6;

  // register indexes
  localparam logic [2:0] RegSync    = 3'd0;
  localparam logic [2:0] RegMaxPay  = 3'd1;
  localparam logic [2:0] RegSilence = 3'd2;
  localparam logic [2:0] RegThresh  = 3'd3;
  localparam logic [2:0] RegBlock   = 3'd4;

  // frame status / phase codes
  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ACCEPT   = 3'd1,
    PH_BADSYNC  = 3'd2,
    PH_OVERSIZE = 3'd3,
    PH_OVERFLOW = 3'd4
  } phase_t;

  localparam logic [2:0] StShort = 3'd1;

  localparam logic [1:0] SrcNone = 2'd0;
  localparam logic [1:0] SrcRing = 2'd1;
  localparam logic [1:0] SrcPad  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BYTE,
    S_JUDGE,
    S_SIL,
    S_CHECK,
    S_PAD,
    S_REPORT,
    S_TICK,
    S_RDWAIT,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // latch input beat
    logic hdr_byte;    // store header byte, bump position
    logic pay_byte;    // payload byte handling
    logic judge;       // evaluate header checks
    logic sil_write;   // write one silence byte
    logic sil_end;     // silence done, resync id
    logic check;       // overflow check, set phase
    logic pad_write;   // write one zero pad byte
    logic frame_end;   // commit frame, build report
    logic tick_start;  // start block if needed, decide source
    logic read_take;   // build sample from ring data
    logic out_clr;     // output beat taken
  } apl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mode;
    logic last;
    logic in_header;
    logic hdr_full;
    logic phase_ok;
    logic sil_more;
    logic pad_more;
    logic need_read;
  } apl_stat_t;

endpackage

>>> rtl/apl_ram.sv
// ----------------------------------------------------------------------------
// apl_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module apl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/apl_ctrl.sv
// ----------------------------------------------------------------------------
// apl_ctrl
// sequencer for frame bytes, silence fill, padding and playback ticks
// ----------------------------------------------------------------------------
module apl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  apl_pkg::apl_stat_t stat,
  output apl_pkg::apl_cmd_t  cmd
);

  apl_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      apl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = apl_pkg::S_BYTE;
        end
      end
      apl_pkg::S_BYTE: begin
        if (stat.mode) begin
          state_next = apl_pkg::S_TICK;
        end else if (stat.in_header) begin
          cmd.hdr_byte = 1'b1;
          if (stat.hdr_full) begin
            state_next = apl_pkg::S_JUDGE;
          end else begin
            state_next = stat.last ? apl_pkg::S_REPORT : apl_pkg::S_IDLE;
          end
        end else begin
          cmd.pay_byte = 1'b1;
          state_next   = stat.last ? apl_pkg::S_PAD : apl_pkg::S_IDLE;
        end
      end
      apl_pkg::S_JUDGE: begin
        cmd.judge  = 1'b1;
        state_next = apl_pkg::S_SIL;
      end
      apl_pkg::S_SIL: begin
        if (!stat.phase_ok) begin
          state_next = stat.last ? apl_pkg::S_REPORT : apl_pkg::S_IDLE;
        end else if (stat.sil_more) begin
          cmd.sil_write = 1'b1;
        end else begin
          cmd.sil_end = 1'b1;
          state_next  = apl_pkg::S_CHECK;
        end
      end
      apl_pkg::S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.last ? apl_pkg::S_PAD : apl_pkg::S_IDLE;
      end
      apl_pkg::S_PAD: begin
        if (stat.pad_more) begin
          cmd.pad_write = 1'b1;
        end else begin
          state_next = apl_pkg::S_REPORT;
        end
      end
      apl_pkg::S_REPORT: begin
        cmd.frame_end = 1'b1;
        state_next    = apl_pkg::S_OUT;
      end
      apl_pkg::S_TICK: begin
        cmd.tick_start = 1'b1;
        state_next     = apl_pkg::S_RDWAIT;
      end
      // ram data for the old read pointer is valid here only
      apl_pkg::S_RDWAIT: begin
        if (stat.need_read) begin
          cmd.read_take = 1'b1;
        end
        state_next = apl_pkg::S_OUT;
      end
      apl_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_clr = 1'b1;
          state_next  = apl_pkg::S_IDLE;
        end
      end
      default: state_next = apl_pkg::S_IDLE;
    endcase
  end

endmodule

>>> rtl/apl_dp.sv
// ----------------------------------------------------------------------------
// apl_dp
// frame parser registers, ring pointers, fill count and result registers
// ----------------------------------------------------------------------------
module apl_dp #(
  parameter int unsigned RING_DEPTH = apl_pkg::RingDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  apl_pkg::apl_cmd_t  cmd,
  output apl_pkg::apl_stat_t stat,
  input  logic               mode,
  input  logic [7:0]         rx_byte,
  input  logic               frame_last,
  input  logic [15:0]        sync_word,
  input  logic [7:0]         max_payload,
  input  logic [7:0]         silence_level,
  input  logic [15:0]        start_threshold,
  input  logic [12:0]        block_samples,
  output logic               kind,
  output logic signed [15:0] sample,
  output logic [1:0]         sample_source,
  output logic [2:0]         frame_status,
  output logic [15:0]        lost_packets
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned FW = AW + 1;

  // latched input beat
  logic       b_mode;
  logic [7:0] b_byte;
  logic       b_last;

  // frame state
  apl_pkg::phase_t phase;
  logic [7:0]  fpos;
  logic [15:0] h_sync, h_id, h_size, lost;
  logic [15:0] expected_id;
  logic [15:0] id_gap;
  logic [7:0]  pdone;
  logic [23:0] sil_left;

  // ring state
  logic [AW-1:0] rptr;
  logic [FW-1:0] fill;
  logic [12:0]   block_rem;
  logic          pad_rest;
  logic          need_read;

  // ram port
  logic          we;
  logic [AW-1:0] addr;
  logic [7:0]    wdata, rdata;
  logic [FW-1:0] room;
  logic [FW-1:0] wofs;

  assign room = FW'(RING_DEPTH) - fill;

  // lost packet count, modulo 65536
  assign id_gap = h_id - expected_id;

  always_comb begin
    we    = 1'b0;
    wdata = b_byte;
    wofs  = fill + FW'(pdone);
    if (cmd.sil_write) begin
      we    = 1'b1;
      wdata = silence_level;
      wofs  = fill;
    end else if (cmd.pad_write) begin
      we    = 1'b1;
      wdata = 8'd0;
    end else if (cmd.pay_byte) begin
      we = (phase == apl_pkg::PH_ACCEPT) && (16'(pdone) < h_size);
    end
    addr = cmd.tick_start ? rptr : AW'(FW'(rptr) + wofs);
  end

  apl_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // status back to the controller
  assign stat.mode      = b_mode;
  assign stat.last      = b_last;
  assign stat.in_header = (phase == apl_pkg::PH_HEADER);
  assign stat.hdr_full  = (fpos == 8'(apl_pkg::HeaderLen - 1));
  assign stat.phase_ok  = (phase == apl_pkg::PH_HEADER);
  assign stat.sil_more  = (sil_left != 24'd0) && (room != '0);
  assign stat.pad_more  = (phase == apl_pkg::PH_ACCEPT) && (16'(pdone) < h_size);
  assign stat.need_read = need_read;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= apl_pkg::PH_HEADER;
      fpos        <= '0;
      h_sync      <= '0;
      h_id        <= '0;
      h_size      <= '0;
      lost        <= '0;
      expected_id <= '0;
      pdone       <= '0;
      sil_left    <= '0;
      rptr        <= '0;
      fill        <= '0;
      block_rem   <= '0;
      pad_rest    <= 1'b0;
      need_read   <= 1'b0;
    end else begin
      // header byte collection
      if (cmd.hdr_byte) begin
        case (fpos)
          8'd0: h_sync[7:0]   <= b_byte;
          8'd1: h_sync[15:8]  <= b_byte;
          8'd2: h_id[7:0]     <= b_byte;
          8'd3: h_id[15:8]    <= b_byte;
          8'd4: h_size[7:0]   <= b_byte;
          8'd5: h_size[15:8]  <= b_byte;
          default: ;
        endcase
        if (fpos != 8'hFF) fpos <= fpos + 8'd1;
      end
      // payload byte
      if (cmd.pay_byte) begin
        if (we) pdone <= pdone + 8'd1;
        if (fpos != 8'hFF) fpos <= fpos + 8'd1;
      end
      // header checks
      if (cmd.judge) begin
        if (h_sync != sync_word) begin
          phase <= apl_pkg::PH_BADSYNC;
        end else if (h_size > 16'(max_payload)) begin
          phase <= apl_pkg::PH_OVERSIZE;
        end else begin
          lost     <= id_gap;
          sil_left <= 24'(id_gap) * 24'(max_payload);
        end
      end
      // silence fill
      if (cmd.sil_write) begin
        fill     <= fill + FW'(1);
        sil_left <= sil_left - 24'd1;
      end
      if (cmd.sil_end && lost != 16'd0) expected_id <= h_id;
      // overflow check
      if (cmd.check) begin
        if (room < FW'(h_size)) begin
          phase <= apl_pkg::PH_OVERFLOW;
        end else begin
          phase       <= apl_pkg::PH_ACCEPT;
          expected_id <= h_id + 16'd1;
        end
      end
      if (cmd.pad_write) pdone <= pdone + 8'd1;
      // frame commit and report
      if (cmd.frame_end) begin
        kind          <= 1'b1;
        sample        <= '0;
        sample_source <= apl_pkg::SrcNone;
        if (phase == apl_pkg::PH_HEADER) begin
          frame_status <= apl_pkg::StShort;
          lost_packets <= '0;
        end else begin
          frame_status <= phase;
          lost_packets <= (phase == apl_pkg::PH_ACCEPT || phase == apl_pkg::PH_OVERFLOW)
                          ? lost : 16'd0;
        end
        if (phase == apl_pkg::PH_ACCEPT) fill <= fill + FW'(h_size);
        phase  <= apl_pkg::PH_HEADER;
        fpos   <= '0;
        h_sync <= '0;
        h_id   <= '0;
        h_size <= '0;
        lost   <= '0;
        pdone  <= '0;
        sil_left <= '0;
      end
      // playback tick
      if (cmd.tick_start) begin
        kind          <= 1'b0;
        sample        <= '0;
        frame_status  <= '0;
        lost_packets  <= '0;
        need_read     <= 1'b0;
        if (block_rem == 13'd0 && 32'(start_threshold) > 32'(fill)) begin
          sample_source <= apl_pkg::SrcNone;
        end else begin
          if ((block_rem == 13'd0 ? 1'b0 : pad_rest) || fill == '0) begin
            pad_rest      <= 1'b1;
            sample_source <= apl_pkg::SrcPad;
          end else begin
            pad_rest      <= 1'b0;
            sample_source <= apl_pkg::SrcRing;
            need_read     <= 1'b1;
            rptr          <= (rptr == AW'(RING_DEPTH - 1)) ? '0 : rptr + AW'(1);
            fill          <= fill - FW'(1);
          end
          block_rem <= (block_rem == 13'd0)
                       ? ((block_samples == 13'd0) ? 13'd0 : block_samples - 13'd1)
                       : block_rem - 13'd1;
        end
      end
      if (cmd.read_take) begin
        sample    <= {rdata ^ 8'h80, 8'h00};
        need_read <= 1'b0;
      end
    end
  end

  // input beat latch
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      b_mode <= mode;
      b_byte <= rx_byte;
      b_last <= frame_last;
    end
  end

endmodule

>>> rtl/audio_packet_loss_fill_buffer.sv
// ----------------------------------------------------------------------------
// audio_packet_loss_fill_buffer
// jitter buffer with silence insertion for lost packets
// ----------------------------------------------------------------------------
// One beat is taken at a time. A plain frame byte passes from S_IDLE
// through S_BYTE back to input ready. A header's sixth byte goes on to
// S_JUDGE and S_SIL; when the frame is dropped for sync or size it leaves
// S_SIL at once, else silence bytes are written one per step (up to
// lost count times max_payload, clipped by free ring space) before S_CHECK.
// A frame's last byte goes through S_PAD, one zero pad byte per missing
// payload byte, then S_REPORT and S_OUT, whose output beat waits until
// taken. Silence and padding go one byte at a time because the ring has a
// single write port. A playback tick passes S_TICK, S_RDWAIT and S_OUT,
// whose beat waits until taken. The ring needs no clearing after reset.
module audio_packet_loss_fill_buffer #(
  parameter int unsigned RING_DEPTH = apl_pkg::RingDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [7:0]         rx_byte,
  input  logic               frame_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic signed [15:0] sample,
  output logic [1:0]         sample_source,
  output logic [2:0]         frame_status,
  output logic [15:0]        lost_packets,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [15:0] sync_word, start_threshold;
  logic [7:0]  max_payload, silence_level;
  logic [12:0] block_samples;

  apl_pkg::apl_cmd_t  cmd;
  apl_pkg::apl_stat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word       <= apl_pkg::SyncReset;
      max_payload     <= apl_pkg::MaxPayReset;
      silence_level   <= apl_pkg::SilenceReset;
      start_threshold <= apl_pkg::ThreshReset;
      block_samples   <= apl_pkg::BlockReset;
    end else if (cfg_we) begin
      case (cfg_index)
        apl_pkg::RegSync:    sync_word       <= cfg_data;
        apl_pkg::RegMaxPay:  max_payload     <= cfg_data[7:0];
        apl_pkg::RegSilence: silence_level   <= cfg_data[7:0];
        apl_pkg::RegThresh:  start_threshold <= cfg_data;
        apl_pkg::RegBlock:   block_samples   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  apl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  apl_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .mode            (mode),
    .rx_byte         (rx_byte),
    .frame_last      (frame_last),
    .sync_word       (sync_word),
    .max_payload     (max_payload),
    .silence_level   (silence_level),
    .start_threshold (start_threshold),
    .block_samples   (block_samples),
    .kind            (kind),
    .sample          (sample),
    .sample_source   (sample_source),
    .frame_status    (frame_status),
    .lost_packets    (lost_packets)
  );

endmodule

>>> rtl/apl_checker.sv
// ----------------------------------------------------------------------------
// apl_checker
// port level checks of the packet loss fill buffer
// ----------------------------------------------------------------------------
`include "audio_packet_loss_fill_buffer_assert.svh"

module apl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic [15:0] sample,
  input logic [1:0]  sample_source,
  input logic [2:0]  frame_status
);

  logic ring_beat;

  // audio beat read from the ring
  assign ring_beat = !kind && (sample_source == apl_pkg::SrcRing);

  // one beat at a time: no input while a result waits
  `APL_ASSERT(a_excl, !(in_ready && out_valid), "input taken while result pending")
  // a result waits until taken
  `APL_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped")
  // audio results carry no frame status
  `APL_ASSERT(a_audio, !(out_valid && !kind) || frame_status == 3'd0, "status on audio")
  // only ring samples are nonzero
  `APL_ASSERT(a_src, !(out_valid && sample != 16'd0) || ring_beat, "nonzero sample off ring")

endmodule

bind audio_packet_loss_fill_buffer apl_checker u_apl_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .kind          (kind),
  .sample        (sample),
  .sample_source (sample_source),
  .frame_status  (frame_status)
);
